/* hdl/cmfpc_pkg.sv */
package cmfpc_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int SLOTS          = 4;
    localparam int SLOT_W         = 2;
    localparam int CNT_W          = 3;
    localparam int THRESH_W       = 52;
    localparam int DEPTH_W        = 32;
    localparam int TAG_W          = 32;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 52'd16777;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEAR,
        ST_CROSS,
        ST_PICK,
        ST_WRITE,
        ST_OUT
    } cmfpc_state_t;

    typedef struct packed {
        logic load;
        logic near_step;
        logic cross_step;
        logic write;
        logic [SLOT_W-1:0] idx;
    } cmfpc_cmd_t;

    typedef struct packed {
        logic drop;
        logic full;
        logic cross_last;
    } cmfpc_stat_t;

    function automatic logic [SLOT_W-1:0] ia_of(input logic [SLOT_W-1:0] k);
        ia_of = (k == 2'd0) ? 2'd1 : 2'd0;
    endfunction

    function automatic logic [SLOT_W-1:0] ib1_of(input logic [SLOT_W-1:0] k);
        ib1_of = (k == 2'd3) ? 2'd2 : 2'd3;
    endfunction

    function automatic logic [SLOT_W-1:0] ib2_of(input logic [SLOT_W-1:0] k);
        ib2_of = (k == 2'd0 || k == 2'd1) ? 2'd2 : 2'd1;
    endfunction

endpackage

/* hdl/cmfpc_ctrl.sv */
module cmfpc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  out_fire,
    input  cmfpc_pkg::cmfpc_stat_t stat,
    output cmfpc_pkg::cmfpc_cmd_t  cmd,
    output logic                  in_ready,
    output logic                  out_valid
);
    import cmfpc_pkg::*;

    cmfpc_state_t      state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.idx        = idx_reg;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_NEAR;
                end
            end
            ST_NEAR:
            begin
                cmd.near_step = 1'b1;
                idx_next      = idx_reg + 2'd1;
                if (idx_reg == SLOT_W'(SLOTS - 1))
                    state_next = ST_PICK;
            end
            ST_PICK:
            begin
                idx_next = '0;
                if (stat.drop)
                    state_next = ST_OUT;
                else if (stat.full)
                    state_next = ST_CROSS;
                else
                    state_next = ST_WRITE;
            end
            ST_CROSS:
            begin
                cmd.cross_step = 1'b1;
                if (stat.cross_last)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == SLOT_W'(SLOTS - 1))
                        state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

/* hdl/cmfpc_dp.sv */
module cmfpc_dp #(
    parameter int COORD_BITS = cmfpc_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [cmfpc_pkg::THRESH_W-1:0]    thresh,
    input  logic signed [cmfpc_pkg::DEPTH_W-1:0] in_depth,
    input  logic [9*COORD_BITS-1:0]           in_vec,
    input  logic [cmfpc_pkg::TAG_W-1:0]       in_tag,
    input  cmfpc_pkg::cmfpc_cmd_t             cmd,
    output cmfpc_pkg::cmfpc_stat_t            stat,
    output logic                              res_stored,
    output logic [cmfpc_pkg::SLOT_W-1:0]      res_slot,
    output logic [cmfpc_pkg::CNT_W-1:0]       res_count
);
    import cmfpc_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;           // coordinate difference
    localparam int PW  = 2 * DW;           // cross term product
    localparam int XW  = PW + 1;           // cross component
    localparam int SW  = 2 * XW + 2;       // squared cross length
    localparam int QW  = 2 * DW + 2;       // squared distance
    localparam int NW  = (QW > THRESH_W) ? QW : THRESH_W;
    localparam int HW  = DW;               // lower half of a cross magnitude
    localparam int MW  = DW + 1;           // shared multiplier operand

    // slot storage
    logic signed [DEPTH_W-1:0] sdepth_reg [SLOTS];
    logic [9*CW-1:0]           svec_reg   [SLOTS];
    logic [TAG_W-1:0]          stag_reg   [SLOTS];
    logic [CNT_W-1:0]          count_reg;

    // latched new contact
    logic signed [DEPTH_W-1:0] ndepth_reg;
    logic [9*CW-1:0]           nvec_reg;
    logic [TAG_W-1:0]          ntag_reg;

    logic                      near_hit_reg;
    logic [SLOT_W-1:0]         near_idx_reg;
    logic                      deep_hit_reg;
    logic [SLOT_W-1:0]         deep_idx_reg;
    logic signed [DEPTH_W-1:0] deep_val_reg;

    // cross-area sequencing: per component two products, a magnitude, then
    // three partial squares on the shared multiplier; one step to compare
    logic [1:0]                 comp_reg;
    logic [2:0]                 step_reg;
    logic signed [PW-1:0]       p_reg;
    logic signed [PW-1:0]       q_reg;
    logic [PW-1:0]              mag_reg;
    logic [SW-1:0]              acc_reg;
    logic [SW-1:0]              best_reg;
    logic [SLOT_W-1:0]          best_idx_reg;

    logic [SLOT_W-1:0]          res_slot_reg;
    logic                       res_stored_reg;

    function automatic logic signed [DW-1:0] pa(input logic [9*CW-1:0] v, input int c);
        pa = DW'($signed(v[(3 + c)*CW +: CW]));
    endfunction

    // near test for entry idx
    logic signed [DW-1:0] d [3];
    logic [QW-1:0]        dist_sq;
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            d[c] = pa(svec_reg[cmd.idx], c) - pa(nvec_reg, c);
        dist_sq = QW'(d[0] * d[0]) + QW'(d[1] * d[1]) + QW'(d[2] * d[2]);
    end

    // cross operands for slot idx
    logic [SLOT_W-1:0]      ka, kb1, kb2;
    logic signed [DW-1:0]   av [3];
    logic signed [DW-1:0]   bv [3];
    logic signed [MW-1:0]   opx, opy;
    logic signed [MW-1:0]   mag_hi, mag_lo;
    logic signed [2*MW-1:0] mul;
    logic signed [PW-1:0]   xdiff;
    logic [SW-1:0]          mul_ext;
    logic [SW-1:0]          term;
    logic                   skip;
    always_comb
    begin
        ka  = ia_of(cmd.idx);
        kb1 = ib1_of(cmd.idx);
        kb2 = ib2_of(cmd.idx);
        for (int c = 0; c < 3; c++)
        begin
            av[c] = pa(nvec_reg, c) - pa(svec_reg[ka], c);
            bv[c] = pa(svec_reg[kb1], c) - pa(svec_reg[kb2], c);
        end
        mag_hi = $signed({1'b0, mag_reg[PW-1:HW]});
        mag_lo = $signed({1'b0, mag_reg[HW-1:0]});
        // components: a1*b2 - a2*b1, a2*b0 - a0*b2, a0*b1 - a1*b0
        case (step_reg)
            3'd0:
            begin
                case (comp_reg)
                    2'd0:    begin opx = MW'(av[1]); opy = MW'(bv[2]); end
                    2'd1:    begin opx = MW'(av[2]); opy = MW'(bv[0]); end
                    default: begin opx = MW'(av[0]); opy = MW'(bv[1]); end
                endcase
            end
            3'd1:
            begin
                case (comp_reg)
                    2'd0:    begin opx = MW'(av[2]); opy = MW'(bv[1]); end
                    2'd1:    begin opx = MW'(av[0]); opy = MW'(bv[2]); end
                    default: begin opx = MW'(av[1]); opy = MW'(bv[0]); end
                endcase
            end
            3'd3:    begin opx = mag_hi; opy = mag_hi; end
            3'd4:    begin opx = mag_hi; opy = mag_lo; end
            3'd5:    begin opx = mag_lo; opy = mag_lo; end
            default: begin opx = '0; opy = '0; end
        endcase
        mul     = opx * opy;
        xdiff   = p_reg - q_reg;
        mul_ext = SW'($unsigned(mul));
        case (step_reg)
            3'd3:    term = mul_ext << (2 * HW);
            3'd4:    term = mul_ext << (HW + 1);
            3'd5:    term = mul_ext;
            default: term = '0;
        endcase
        skip = deep_hit_reg && (deep_idx_reg == cmd.idx);
    end

    // last step of a pass only compares the finished sum
    assign stat.cross_last = (comp_reg == 2'd2) && (step_reg == 3'd6);

    assign stat.drop = near_hit_reg && (sdepth_reg[near_idx_reg] < ndepth_reg);
    assign stat.full = (count_reg == CNT_W'(SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.write && !stat.full)
        begin
            count_reg <= count_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ndepth_reg     <= in_depth;
            nvec_reg       <= in_vec;
            ntag_reg       <= in_tag;
            near_hit_reg   <= 1'b0;
            deep_hit_reg   <= 1'b0;
            deep_val_reg   <= in_depth;
            comp_reg       <= '0;
            step_reg       <= '0;
            acc_reg        <= '0;
            best_reg       <= '0;
            best_idx_reg   <= '0;
            res_stored_reg <= 1'b0;
            res_slot_reg   <= '0;
        end
        if (cmd.near_step)
        begin
            if (CNT_W'(cmd.idx) < count_reg && NW'(dist_sq) < NW'(thresh))
            begin
                near_hit_reg <= 1'b1;
                near_idx_reg <= cmd.idx;
            end
            if (sdepth_reg[cmd.idx] < deep_val_reg)
            begin
                deep_hit_reg <= 1'b1;
                deep_idx_reg <= cmd.idx;
                deep_val_reg <= sdepth_reg[cmd.idx];
            end
        end
        if (cmd.cross_step)
        begin
            case (step_reg)
                3'd0:    p_reg   <= PW'(mul);
                3'd1:    q_reg   <= PW'(mul);
                3'd2:    mag_reg <= xdiff[PW-1] ? -xdiff : xdiff;
                3'd3,
                3'd4,
                3'd5:    acc_reg <= acc_reg + term;
                default: ;
            endcase
            if (stat.cross_last)
            begin
                comp_reg <= '0;
                step_reg <= '0;
                acc_reg  <= '0;
                if (!skip && acc_reg > best_reg)
                begin
                    best_reg     <= acc_reg;
                    best_idx_reg <= cmd.idx;
                end
            end
            else if (step_reg == 3'd5 && comp_reg != 2'd2)
            begin
                comp_reg <= comp_reg + 2'd1;
                step_reg <= '0;
            end
            else
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
        if (cmd.write)
        begin
            res_stored_reg <= 1'b1;
            res_slot_reg   <= stat.full ? best_idx_reg : count_reg[SLOT_W-1:0];
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            if (cmd.write && k == int'(stat.full ? best_idx_reg : count_reg[SLOT_W-1:0]))
            begin
                sdepth_reg[k] <= ndepth_reg;
                svec_reg[k]   <= nvec_reg;
                stag_reg[k]   <= ntag_reg;
            end
        end
    end

    assign res_stored = res_stored_reg;
    assign res_slot   = res_slot_reg;
    assign res_count  = count_reg;

endmodule

/* hdl/contact_manifold_four_point_cache.sv */
// Flow per input beat: the contact is latched and its distance to each of the four
// slots is scanned; unless it is dropped, a slot is then written. When all four slots
// are full, four cross-area passes on one shared multiplier come before the write.
// One item at a time; the next input beat is taken the cycle after the result beat.
// Reset (rst_n low, asynchronous) empties the cache and sets the threshold
// to its default; slot contents stay undefined until written.
module contact_manifold_four_point_cache #(
    parameter int COORD_BITS = cmfpc_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cmfpc_pkg::THRESH_W-1:0]     cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // depth, normal_x..z, point_a_x..z, point_b_x..z, tag (low to high)
    input  logic [((64 + 9*COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // stored, slot, count_after (low to high), padded to 8 bits
    output logic [7:0]                         m_axis_tdata
);
    import cmfpc_pkg::*;

    cmfpc_cmd_t          cmd;
    cmfpc_stat_t         stat;
    logic [THRESH_W-1:0] thresh_reg;
    logic                res_stored;
    logic [SLOT_W-1:0]   res_slot;
    logic [CNT_W-1:0]    res_count;

    // hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= THRESH_RESET;
        else if (cfg_we)
            thresh_reg <= cfg_wdata;
    end

    cmfpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid && s_axis_tready),
        .out_fire (m_axis_tvalid && m_axis_tready),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid)
    );

    cmfpc_dp #(.COORD_BITS(COORD_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .thresh    (thresh_reg),
        .in_depth  (s_axis_tdata[DEPTH_W-1:0]),
        .in_vec    (s_axis_tdata[DEPTH_W +: 9*COORD_BITS]),
        .in_tag    (s_axis_tdata[DEPTH_W + 9*COORD_BITS +: TAG_W]),
        .cmd       (cmd),
        .stat      (stat),
        .res_stored(res_stored),
        .res_slot  (res_slot),
        .res_count (res_count)
    );

    assign m_axis_tdata = {2'b00, res_count, res_slot, res_stored};

endmodule

/* tb/sv/tb_contact_manifold_four_point_cache.sv */
`timescale 1ns / 1ps

module tb_contact_manifold_four_point_cache;

    import cmfpc_pkg::*;

    localparam int CB     = 24;
    localparam int DATA_W = ((64 + 9*CB + 7) / 8) * 8;
    localparam logic [THRESH_W-1:0] THRESH_MAX = {THRESH_W{1'b1}};
    localparam logic [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};

    // One contact as it travels on the input bus.
    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [2:0][CB-1:0]   pb;
        logic [2:0][CB-1:0]   pa;
        logic [2:0][CB-1:0]   nrm;
        logic [DEPTH_W-1:0]   depth;
    } contact_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [THRESH_W-1:0]  cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // depth, normal_x..z, point_a_x..z, point_b_x..z, tag (low to high)
    logic [DATA_W-1:0]    s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // stored, slot, count_after (low to high), padded to 8 bits
    logic [7:0]           m_axis_tdata;

    contact_manifold_four_point_cache #(.COORD_BITS(CB)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Shadow copy of the cache: only what decides the results is kept.
    logic [THRESH_W-1:0] near_thresh;
    longint              cache_depth [SLOTS];
    longint              cache_pa    [SLOTS][3];
    int                  cache_count;

    logic [7:0] pending_results[$];
    int         errors;
    int         hold_cycles;    // long receiver stall request, consumed by the ready process
    bit         rx_quiet;       // receiver always ready while set
    bit         tx_quiet;       // sender never idles while set
    int         next_gap;

    // Squared length of cross(a, b); exact, fits well inside 128 bits.
    function automatic logic [127:0] cross_area_sq(input longint a0, input longint a1,
                                                   input longint a2, input longint b0,
                                                   input longint b1, input longint b2);
        logic signed [127:0] x;
        logic signed [127:0] y;
        logic signed [127:0] z;
        x = a1 * b2 - a2 * b1;
        y = a2 * b0 - a0 * b2;
        z = a0 * b1 - a1 * b0;
        return x * x + y * y + z * z;
    endfunction

    // Choose the slot to overwrite when all four are full.
    function automatic int replace_slot(input longint na [3], input longint nd);
        int          base_a  [SLOTS] = '{1, 0, 0, 0};
        int          edge_hi [SLOTS] = '{3, 3, 3, 2};
        int          edge_lo [SLOTS] = '{2, 2, 1, 1};
        logic [127:0] area   [SLOTS];
        longint      av [3];
        longint      bv [3];
        longint      best;
        int          deepest;
        int          sel;
        best = nd;
        deepest = -1;
        sel = 0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (cache_depth[k] < best)
            begin
                deepest = k;
                best = cache_depth[k];
            end
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                av[j] = na[j] - cache_pa[base_a[k]][j];
                bv[j] = cache_pa[edge_hi[k]][j] - cache_pa[edge_lo[k]][j];
            end
            area[k] = (k == deepest) ? 128'd0
                    : cross_area_sq(av[0], av[1], av[2], bv[0], bv[1], bv[2]);
        end
        for (int k = 1; k < SLOTS; k++)
        begin
            if (area[k] > area[sel])
                sel = k;
        end
        return sel;
    endfunction

    // Apply one contact to the shadow cache and return the expected result beat.
    function automatic logic [7:0] insert_contact(input contact_t c);
        longint       nd;
        longint       na [3];
        longint       diff;
        logic [63:0]  dist_sq;
        int           near_idx;
        int           slot;
        nd = longint'($signed(c.depth));
        for (int j = 0; j < 3; j++)
            na[j] = longint'($signed(c.pa[j]));
        near_idx = -1;
        for (int i = 0; i < cache_count; i++)
        begin
            dist_sq = 64'd0;
            for (int j = 0; j < 3; j++)
            begin
                diff = cache_pa[i][j] - na[j];
                dist_sq += 64'(diff * diff);
            end
            if (dist_sq < 64'(near_thresh))
                near_idx = i;
        end
        if (near_idx >= 0 && cache_depth[near_idx] < nd)
            return {2'b00, 3'(cache_count), 2'b00, 1'b0};
        if (cache_count < SLOTS)
        begin
            slot = cache_count;
            cache_count++;
        end
        else
            slot = replace_slot(na, nd);
        cache_depth[slot] = nd;
        for (int j = 0; j < 3; j++)
            cache_pa[slot][j] = na[j];
        return {2'b00, 3'(cache_count), 2'(slot), 1'b1};
    endfunction

    function automatic int pick_gap();
        if (tx_quiet || $urandom_range(0, 2) != 0)
            return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Offer one beat, wait for the handshake, record the expectation, then maybe idle a while.
    task automatic send_contact(input contact_t c);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(insert_contact(c));
        next_gap = pick_gap();
        if (next_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (next_gap) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every result, then let the block settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        near_thresh = value;
    endtask

    function automatic contact_t make_contact(input logic [DEPTH_W-1:0] depth,
                                              input logic [CB-1:0] ax,
                                              input logic [CB-1:0] ay,
                                              input logic [CB-1:0] az,
                                              input logic [TAG_W-1:0] tag);
        contact_t c;
        c.depth  = depth;
        c.pa[0]  = ax;
        c.pa[1]  = ay;
        c.pa[2]  = az;
        for (int j = 0; j < 3; j++)
        begin
            c.nrm[j] = CB'($urandom);
            c.pb[j]  = CB'($urandom);
        end
        c.tag = tag;
        return c;
    endfunction

    // Mostly points around a few cluster centers so near hits and
    // replacements happen often; some fully random contacts for bit coverage.
    function automatic contact_t random_contact(input int spread);
        contact_t c;
        int       center;
        c = make_contact(DEPTH_W'($urandom), CB'($urandom), CB'($urandom),
                         CB'($urandom), $urandom);
        if ($urandom_range(0, 99) < 85)
        begin
            center = $urandom_range(0, 3) * 200;
            for (int j = 0; j < 3; j++)
                c.pa[j] = CB'(center - 600 * j + $signed($urandom_range(0, 2*spread)) - spread);
            c.depth = DEPTH_W'($signed($urandom_range(0, 2000)) - 1000);
        end
        return c;
    endfunction

    task automatic test_fill_and_near();
        // empty cache, then a deeper contact at the same point is appended
        send_contact(make_contact(32'sd0, 24'd0, 24'd0, 24'd0, 32'h0));
        send_contact(make_contact(-32'sd100, 24'd0, 24'd0, 24'd0, 32'hFFFF_FFFF));
        // shallower than the last near point: drop
        send_contact(make_contact(32'sd0, 24'd0, 24'd0, 24'd0, 32'h1));
        // equal depth to the near point: keep
        send_contact(make_contact(-32'sd100, 24'd1, 24'd0, 24'd0, 32'h2));
        // full cache; extreme coordinates and depths drive replacement
        send_contact(make_contact(32'h8000_0000, C_MIN, C_MAX, C_MIN, 32'h3));
        send_contact(make_contact(32'h7FFF_FFFF, C_MAX, C_MIN, C_MAX, 32'h4));
        send_contact(make_contact(32'h7FFF_FFFF, C_MIN, C_MIN, C_MIN, 32'h5));
        send_contact(make_contact(32'h8000_0000, C_MAX, C_MAX, C_MAX, 32'h6));
        send_contact(make_contact(32'sd5, 24'd100, 24'd0, 24'd0, 32'h7));
    endtask

    task automatic test_threshold_tie();
        write_threshold(52'd10000);
        // squared distance exactly at the threshold is not near; one below is
        send_contact(make_contact(32'sd7000, 24'd100, 24'd0, 24'd0, 32'h10));
        send_contact(make_contact(32'sd7000, 24'd99, 24'd0, 24'd0, 32'h11));
        send_contact(make_contact(32'sd7000, 24'd0, 24'd100, 24'd0, 32'h12));
    endtask

    task automatic test_zero_area();
        // nothing counts as near; four identical points give zero areas
        write_threshold(52'd0);
        repeat (5) send_contact(make_contact(32'sd50, 24'd7, 24'd7, 24'd7, 32'h20));
        send_contact(make_contact(32'sd60, 24'd7, 24'd7, 24'd7, 32'h21));
        // everything counts as near
        write_threshold(THRESH_MAX);
        send_contact(make_contact(32'h7FFF_FFFF, C_MAX, C_MIN, C_MAX, 32'h22));
        send_contact(make_contact(32'h8000_0000, C_MIN, C_MAX, C_MIN, 32'h23));
    endtask

    task automatic test_random(input logic [THRESH_W-1:0] thresh, input int items,
                               input int spread);
        write_threshold(thresh);
        for (int n = 0; n < items; n++)
        begin
            if (n % 150 == 0)
            begin
                tx_quiet = $urandom_range(0, 2) == 0;
                rx_quiet = $urandom_range(0, 2) == 0;
            end
            send_contact(random_contact(spread));
        end
        tx_quiet = 0;
        rx_quiet = 0;
    endtask

    task automatic test_backpressure();
        // stall the receiver long enough that the block backs up its input
        hold_cycles = 300;
        tx_quiet = 1;
        repeat (25) send_contact(random_contact(60));
        tx_quiet = 0;
        // sender pauses until everything has come back
        wait_idle();
        repeat (10) send_contact(random_contact(60));
    endtask

    // Receiver: random stalls, long holds on request, quiet stretches.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end
            else if (rx_quiet)
                m_axis_tready <= 1'b1;
            else if ($urandom_range(0, 60) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= $urandom_range(0, 3) != 0;
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want[0])
                begin
                    $display("%0t: stored expected %0d actual %0d", $time, want[0],
                             m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[2:1] !== want[2:1])
                begin
                    $display("%0t: slot expected %0d actual %0d", $time, want[2:1],
                             m_axis_tdata[2:1]);
                    errors++;
                end
                if (m_axis_tdata[5:3] !== want[5:3])
                begin
                    $display("%0t: count_after expected %0d actual %0d", $time, want[5:3],
                             m_axis_tdata[5:3]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        errors        = 0;
        hold_cycles   = 0;
        rx_quiet      = 0;
        tx_quiet      = 0;
        near_thresh   = THRESH_RESET;
        cache_count   = 0;
        for (int k = 0; k < SLOTS; k++)
        begin
            cache_depth[k] = 0;
            for (int j = 0; j < 3; j++)
                cache_pa[k][j] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_near();
        test_threshold_tie();
        test_zero_area();
        test_random(THRESH_RESET, 450, 120);
        test_backpressure();
        test_random(52'(($urandom_range(0, 400) ** 2)), 450, 300);
        test_random(THRESH_MAX, 200, 60);
        test_random(52'd0, 350, 60);
        test_random({8'($urandom_range(0, 255)), $urandom, 12'($urandom)}, 150, 60);
        test_random(THRESH_RESET, 250, 40);

        wait_idle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/cmfpc_pkg.sv
hdl/cmfpc_ctrl.sv
hdl/cmfpc_dp.sv
hdl/contact_manifold_four_point_cache.sv
tb/sv/tb_contact_manifold_four_point_cache.sv
